[rtl/core/dbdp_pkg.sv]
// Shared types and constants for the downscale / blend / display packer.
// Used by dbdp_ctrl, dbdp_datapath and the top level; no dependencies.
package dbdp_pkg;

  // Request commands (carried on s_tuser)
  localparam logic [2:0] CMD_PIXEL     = 3'd0;
  localparam logic [2:0] CMD_SRC_START = 3'd1;
  localparam logic [2:0] CMD_TGT_START = 3'd2;
  localparam logic [2:0] CMD_READ      = 3'd3;
  localparam logic [2:0] CMD_FRAME_END = 3'd4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 5;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_SKIP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_LAST    = 2'd2;

  // Register reset values
  localparam logic [4:0] LINE_SKIP_RST     = 5'd8;
  localparam logic [4:0] COLUMN_OFFSET_RST = 5'd8;
  localparam logic [1:0] BLEND_LAST_RST    = 2'd1;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] src_line;
    logic [7:0] src_column;
    logic [1:0] shade;
    logic [2:0] page;
    logic [6:0] target_column;
  } item_t;

  // Controller -> datapath
  typedef struct packed {
    logic clear_en;   // clearing pass step
    logic load_item;  // capture accepted request
    logic exec;       // issue memory reads
    logic commit;     // apply state updates and memory writes
    logic load_out;   // load result register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic has_result;
  } status_t;

endpackage

[rtl/core/dbdp_ctrl.sv]
// Sequencer for the packer: clearing pass, accept, read, commit.
// Depends on dbdp_pkg (cmd_t, status_t).
module dbdp_ctrl
  import dbdp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  output logic    m_tvalid,
  input  logic    m_tready,
  input  status_t sts,
  output cmd_t    cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       m_valid;
  logic       stall;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = m_valid;
  // result slot still occupied
  assign stall    = sts.has_result && m_valid && !m_tready;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!stall) begin
          cmd.commit   = 1'b1;
          cmd.load_out = sts.has_result;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) m_valid <= 1'b1;
      else if (m_tready) m_valid <= 1'b0;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_valid || m_tready))
    else $error("result register overwritten");

  a_seq_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
    else $error("request accepted while previous one in flight");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (!s_tready && !m_valid))
    else $error("activity during clearing pass");

endmodule

[rtl/core/dbdp_datapath.sv]
// Datapath: config registers, line store, eight row-banked frame stores,
// slot ring, blend counter and result register. Depends on dbdp_pkg.
module dbdp_datapath
  import dbdp_pkg::*;
#(
  parameter int TARGET_WIDTH  = 96,
  parameter int TARGET_HEIGHT = 64,
  parameter int SOURCE_WIDTH  = 160,
  parameter int FRAME_SLOTS   = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output status_t              sts,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  item_t                in_item,
  output logic [7:0]           out_byte,
  output logic                 out_done
);

  localparam int PAGES      = (TARGET_HEIGHT + 7) / 8;
  localparam int BANK_DEPTH = FRAME_SLOTS * PAGES * TARGET_WIDTH;
  localparam int BA_W       = $clog2(BANK_DEPTH);
  localparam int LS_DEPTH   = (SOURCE_WIDTH + 1) / 2;
  localparam int LS_AW      = (LS_DEPTH > 1) ? $clog2(LS_DEPTH) : 1;
  localparam int CLR_DEPTH  = (BANK_DEPTH > LS_DEPTH) ? BANK_DEPTH : LS_DEPTH;
  localparam int CLR_W      = $clog2(CLR_DEPTH);
  localparam logic [1:0] SLOT_RST = 2'(1 % FRAME_SLOTS);

  item_t            item;
  logic [4:0]       line_skip;
  logic [4:0]       column_offset;
  logic [1:0]       blend_last;
  logic [1:0]       held_pixel;
  logic [1:0]       write_slot;
  logic [1:0]       read_slot;
  logic [1:0]       blend_count;
  logic [CLR_W-1:0] clr_cnt;

  logic [1:0]       bank_q [8];
  logic [1:0]       ls_even [LS_DEPTH];
  logic [1:0]       ls_odd  [LS_DEPTH];
  logic [1:0]       ls_even_q;
  logic [1:0]       ls_odd_q;

  logic             is_pixel, is_read, is_end;
  logic             pix_ok, odd_line, odd_col, x_ok;
  logic [7:0]       rel;
  logic [7:0]       tgt_x;
  logic [6:0]       row;
  logic [3:0]       sum;
  logic [1:0]       blended;
  logic [LS_AW-1:0] ls_addr;
  logic [BA_W-1:0]  wr_addr;
  logic [BA_W-1:0]  rd_addr;
  logic             frame_we, ls_we, held_we;
  logic             clear_bank, clear_ls;
  logic             wrap;
  logic [7:0]       read_bits;

  function automatic logic [1:0] ring_next(input logic [1:0] slot, input logic [1:0] other);
    logic [2:0] n;
    n = {1'b0, slot} + 3'd1;
    if (n >= 3'(FRAME_SLOTS)) n = '0;
    return (n[1:0] != other) ? n[1:0] : slot;
  endfunction

  // decode of the held request
  assign is_pixel = (item.command == CMD_PIXEL);
  assign is_read  = (item.command == CMD_READ);
  assign is_end   = (item.command == CMD_FRAME_END);

  assign rel      = item.src_line - {3'b0, line_skip};
  assign pix_ok   = (item.src_line >= {3'b0, line_skip})
                 && ({2'b0, rel} < 10'(2 * TARGET_HEIGHT))
                 && ({2'b0, item.src_column} < 10'(SOURCE_WIDTH));
  assign odd_line = rel[0];
  assign odd_col  = item.src_column[0];
  assign row      = rel[7:1];
  assign ls_addr  = LS_AW'(item.src_column[7:1]);
  assign tgt_x    = {1'b0, item.src_column[7:1]} + {3'b0, column_offset};
  assign x_ok     = ({1'b0, tgt_x} < 9'(TARGET_WIDTH));

  // 2x2 box average
  assign sum      = {2'b0, held_pixel} + {2'b0, item.shade}
                  + {2'b0, ls_even_q} + {2'b0, ls_odd_q};
  assign blended  = sum[3:2];

  assign wr_addr  = BA_W'((32'(write_slot) * PAGES + 32'(row[6:3])) * TARGET_WIDTH
                          + 32'(tgt_x));
  assign rd_addr  = BA_W'((32'(read_slot) * PAGES + 32'(item.page)) * TARGET_WIDTH
                          + 32'(item.target_column));

  assign frame_we   = cmd.commit && is_pixel && pix_ok && odd_line && odd_col && x_ok;
  assign ls_we      = cmd.commit && is_pixel && pix_ok && !odd_line;
  assign held_we    = cmd.commit && is_pixel && pix_ok && odd_line && !odd_col;
  assign clear_bank = cmd.clear_en && (32'(clr_cnt) < BANK_DEPTH);
  assign clear_ls   = cmd.clear_en && (32'(clr_cnt) < LS_DEPTH);
  assign wrap       = (blend_count == blend_last);

  assign sts.clear_done = (32'(clr_cnt) == CLR_DEPTH - 1);
  assign sts.has_result = is_read || is_end;

  // bank i holds rows with row % 8 == i, so one read serves a whole page
  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [1:0] mem [BANK_DEPTH];
    always_ff @(posedge clk) begin
      if (clear_bank) begin
        mem[clr_cnt[BA_W-1:0]] <= '0;
      end else if (frame_we && (row[2:0] == 3'(b))) begin
        mem[wr_addr] <= blended;
      end
      if (cmd.exec) bank_q[b] <= mem[rd_addr];
    end
  end

  // line store split by column parity: both pixels above a pair in one read
  always_ff @(posedge clk) begin
    if (clear_ls) begin
      ls_even[clr_cnt[LS_AW-1:0]] <= '0;
      ls_odd[clr_cnt[LS_AW-1:0]]  <= '0;
    end else if (ls_we && !odd_col) begin
      ls_even[ls_addr] <= item.shade;
    end else if (ls_we && odd_col) begin
      ls_odd[ls_addr] <= item.shade;
    end
    if (cmd.exec) begin
      ls_even_q <= ls_even[ls_addr];
      ls_odd_q  <= ls_odd[ls_addr];
    end
  end

  always_comb begin
    logic col_ok;
    col_ok = (32'(item.target_column) < TARGET_WIDTH);
    for (int i = 0; i < 8; i++) begin
      read_bits[i] = col_ok && ((32'(item.page) * 8 + 32'(i)) < TARGET_HEIGHT)
                  && (bank_q[i] > blend_count);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= in_item;
    if (cmd.load_out) begin
      out_byte <= is_read ? read_bits : 8'd0;
      out_done <= is_end && wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_skip     <= LINE_SKIP_RST;
      column_offset <= COLUMN_OFFSET_RST;
      blend_last    <= BLEND_LAST_RST;
      held_pixel    <= '0;
      write_slot    <= SLOT_RST;
      read_slot     <= '0;
      blend_count   <= '0;
      clr_cnt       <= '0;
    end else begin
      if (cmd.clear_en) clr_cnt <= clr_cnt + 1'b1;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LINE_SKIP:     line_skip     <= cfg_data;
          REG_COLUMN_OFFSET: column_offset <= cfg_data;
          REG_BLEND_LAST:    blend_last    <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (held_we) held_pixel <= item.shade;
      if (cmd.commit) begin
        case (item.command)
          CMD_SRC_START: write_slot <= ring_next(write_slot, read_slot);
          CMD_TGT_START: if (blend_count == 2'd0) read_slot <= ring_next(read_slot, write_slot);
          CMD_FRAME_END: blend_count <= wrap ? 2'd0 : blend_count + 2'd1;
          default: ;
        endcase
      end
    end
  end

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (32'(write_slot) < FRAME_SLOTS) && (32'(read_slot) < FRAME_SLOTS))
    else $error("slot out of ring");

  a_slots_apart: assert property (@(posedge clk) disable iff (rst)
    (FRAME_SLOTS == 1) || (write_slot != read_slot))
    else $error("write and read slots collided");

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_en |-> !(frame_we || ls_we || held_we))
    else $error("store write during clearing pass");

endmodule

[rtl/core/downscale_blend_display_packer_unit.sv]
// A request is captured, its line-store and frame-store reads are registered, and at commit
// its result is loaded into the result register; the commit of a read or frame-end request
// waits while a previous result still waits on m_tready. A new request is accepted only
// after the last one has committed. Reset: rst is synchronous; afterwards a clearing pass
// walks every frame-store and line-store address and zeroes them with s_tready low.
// Config writes are taken at any time; registers reset to 8, 8 and 1.
module downscale_blend_display_packer_unit
  import dbdp_pkg::*;
#(
  parameter int TARGET_WIDTH  = 96,
  parameter int TARGET_HEIGHT = 64,
  parameter int SOURCE_WIDTH  = 160,
  parameter int FRAME_SLOTS   = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // request stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // s_tdata: src_line[7:0], src_column[15:8], shade[17:16], page[20:18],
  //          target_column[27:21], zero pad[31:28]
  input  logic [31:0]          s_tdata,
  // s_tuser: command[2:0]
  input  logic [2:0]           s_tuser,
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // m_tdata: packed_byte[7:0]
  output logic [7:0]           m_tdata,
  // m_tuser: frame_done[0]
  output logic                 m_tuser
);

  cmd_t    cmd;
  status_t sts;
  item_t   in_item;

  // unpack the request; pad bits of s_tdata are ignored
  assign in_item.command       = s_tuser;
  assign in_item.src_line      = s_tdata[7:0];
  assign in_item.src_column    = s_tdata[15:8];
  assign in_item.shade         = s_tdata[17:16];
  assign in_item.page          = s_tdata[20:18];
  assign in_item.target_column = s_tdata[27:21];

  // sequencer: clear pass, then capture -> read -> commit per request; holds the commit
  // of a read or frame-end request while a previous result still waits on m_tready
  dbdp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // stores, slot ring, blend counter and the result register
  dbdp_datapath #(
    .TARGET_WIDTH  (TARGET_WIDTH),
    .TARGET_HEIGHT (TARGET_HEIGHT),
    .SOURCE_WIDTH  (SOURCE_WIDTH),
    .FRAME_SLOTS   (FRAME_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_byte  (m_tdata),
    .out_done  (m_tuser)
  );

endmodule
